FILE: sv/strict_priority_multi_fifo_macros.svh
// assertion macros used by the strict priority queue control module
`ifndef STRICT_PRIORITY_MULTI_FIFO_MACROS_SVH
`define STRICT_PRIORITY_MULTI_FIFO_MACROS_SVH
`ifndef SYNTHESIS
`define SPMF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPMF_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SPMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPMF_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: sv/spmf_pkg.sv
// types and codes of the strict priority multilevel queue
package spmf_pkg;

	// request codes
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// result codes
	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_SERVED   = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADLEVEL = 3'd4
	} status_t;

	// decision of the queue control for one transaction
	typedef struct packed {
		status_t status;
		logic    wr_en;
		logic    rd_en;
	} dec_t;

endpackage

FILE: sv/spmf_store.sv
// entry storage ram: one write or one registered read per cycle
module spmf_store #(
	parameter int WIDTH   = 16,
	parameter int ENTRIES = 192,
	parameter int ADDR_W  = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wr_data,
	output logic [WIDTH-1:0]  rd_data_s1
);

	logic [WIDTH-1:0] mem_q [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
	end

	// registered read port, holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[addr];
		end
	end

endmodule

FILE: sv/spmf_ctrl.sv
// ring pointers, fill counts and the priority decision of the queue
`include "strict_priority_multi_fifo_macros.svh"
module spmf_ctrl #(
	parameter int LEVELS = 3,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 8,
	parameter int LVL_W  = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  spmf_pkg::op_t       op,
	input  logic [1:0]          level,
	output spmf_pkg::dec_t      dec,
	output logic [ADDR_W-1:0]   addr,
	output logic [LVL_W-1:0]    sel_lvl
);
	import spmf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PTR_W-1:0] head_q [LEVELS];
	logic [PTR_W-1:0] tail_q [LEVELS];
	logic [CNT_W-1:0] cnt_q  [LEVELS];

	logic [LEVELS-1:0] nonempty;
	logic              lvl_ok;
	logic [LVL_W-1:0]  enq_idx;
	logic [LVL_W-1:0]  ring_idx;
	logic [PTR_W-1:0]  ring_ptr;

	// per-level occupancy
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			nonempty[l] = (cnt_q[l] != '0);
		end
	end

	// highest priority non-empty level, level 0 wins
	always_comb begin
		sel_lvl = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (nonempty[l]) begin
				sel_lvl = LVL_W'(l);
			end
		end
	end

	assign lvl_ok  = (int'(level) < LEVELS);
	assign enq_idx = LVL_W'(level);

	// decision for the current request
	always_comb begin
		dec = '{status: ST_EMPTY, wr_en: 1'b0, rd_en: 1'b0};
		if (op == OP_ENQ) begin
			priority if (!lvl_ok) begin
				dec.status = ST_BADLEVEL;
			end else if (cnt_q[enq_idx] == CNT_W'(DEPTH)) begin
				dec.status = ST_FULL;
			end else begin
				dec.status = ST_ENQUEUED;
				dec.wr_en  = 1'b1;
			end
		end else begin
			if (|nonempty) begin
				dec.status = ST_SERVED;
				dec.rd_en  = 1'b1;
			end else begin
				dec.status = ST_EMPTY;
			end
		end
	end

	// ring address: level base plus ring pointer
	assign ring_idx = (op == OP_ENQ) ? enq_idx : sel_lvl;
	assign ring_ptr = (op == OP_ENQ) ? tail_q[enq_idx] : head_q[sel_lvl];
	assign addr     = ADDR_W'(int'(ring_idx) * DEPTH) + ADDR_W'(ring_ptr);

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else if (accept) begin
			if (dec.wr_en) begin
				tail_q[enq_idx] <= (tail_q[enq_idx] == PTR_W'(DEPTH - 1)) ? '0
					: tail_q[enq_idx] + PTR_W'(1);
				cnt_q[enq_idx]  <= cnt_q[enq_idx] + CNT_W'(1);
			end
			if (dec.rd_en) begin
				head_q[sel_lvl] <= (head_q[sel_lvl] == PTR_W'(DEPTH - 1)) ? '0
					: head_q[sel_lvl] + PTR_W'(1);
				cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - CNT_W'(1);
			end
		end
	end

	// checks
	`SPMF_ASSERT(a_served_nonempty, clk, arst_n, (dec.status == ST_SERVED) |-> (cnt_q[sel_lvl] != '0), "served level has no entries")
	`SPMF_ASSERT(a_empty_all_zero, clk, arst_n, (dec.status == ST_EMPTY) |-> (nonempty == '0), "empty reported with entries held")
	`SPMF_ASSERT(a_enq_count, clk, arst_n, (accept && dec.wr_en) |=> (cnt_q[$past(enq_idx)] == $past(cnt_q[enq_idx]) + CNT_W'(1)), "fill count not advanced on enqueue")
	`SPMF_NEVER(a_wr_rd_excl, clk, arst_n, dec.wr_en && dec.rd_en, "write and read issued together")

endmodule

FILE: sv/strict_priority_multi_fifo.sv
// strict priority multilevel queue: one result transaction per request
// throughput: one request per cycle while a held result is not stalled; the result leaves the cycle after acceptance
// the request is decided and the ring ram read or written in the accept cycle,
// the registered ram read port and result register form the single output stage
// reset clears ring pointers, fill counts and the output valid; the ram is not cleared
module strict_priority_multi_fifo #(
	parameter int LEVELS  = 3,
	parameter int DEPTH   = 64,
	parameter int ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [1:0]  level,
	input  logic [15:0] entry_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] served_id,
	output logic [1:0]  served_level
);
	import spmf_pkg::*;

	localparam int ENTRIES = LEVELS * DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int EXT_W   = (ID_BITS > 16) ? ID_BITS : 16;

	logic               accept;
	dec_t               dec;
	logic [ADDR_W-1:0]  addr;
	logic [LVL_W-1:0]   sel_lvl;
	logic [ID_BITS-1:0] rd_data_s1;
	logic [EXT_W-1:0]   rd_ext;

	logic               valid_s1;
	status_t            status_s1;
	logic [LVL_W-1:0]   level_s1;

	// input handshake: blocked only by a result that cannot leave
	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	spmf_ctrl #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.LVL_W  (LVL_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (op_t'(op)),
		.level   (level),
		.dec     (dec),
		.addr    (addr),
		.sel_lvl (sel_lvl)
	);

	spmf_store #(
		.WIDTH   (ID_BITS),
		.ENTRIES (ENTRIES),
		.ADDR_W  (ADDR_W)
	) u_store (
		.clk        (clk),
		.wr_en      (accept && dec.wr_en),
		.rd_en      (accept && dec.rd_en),
		.addr       (addr),
		.wr_data    (ID_BITS'(entry_id)),
		.rd_data_s1 (rd_data_s1)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= dec.status;
			level_s1  <= sel_lvl;
		end
	end

	// result fields, served id and level zero unless an entry was served
	assign rd_ext       = EXT_W'(rd_data_s1);
	assign out_valid    = valid_s1;
	assign status       = status_s1;
	assign served_id    = (status_s1 == ST_SERVED) ? rd_ext[15:0] : 16'd0;
	assign served_level = (status_s1 == ST_SERVED) ? 2'(level_s1) : 2'd0;

endmodule
